// ===== design/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and codes for the LRU block buffer cache
// Command and status codes, field widths, sequencer states and the result
// record of the slot compare unit.
// ----------------------------------------------------------------------------
package lbc_pkg;

  // Fixed field widths of the command and result channels
  localparam int CMD_W      = 2;
  localparam int OWNER_ID_W = 16;
  localparam int BLOCK_NO_W = 32;
  localparam int SLOT_FLD_W = 4;
  localparam int STATUS_W   = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BUSY      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NONE_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_HELD  = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_GET_END,
    ST_SEL,
    ST_SEL_CHK
  } lbc_state_t;

  // Verdict of the slot compare unit for one slot
  typedef struct packed {
    logic match;
    logic hit_better;
    logic vic_better;
  } lbc_cmp_t;

endpackage

// ===== design/lru_block_buffer_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit: LRU buffer slot table with get/mark/release
// Holds SLOT_COUNT slots of owner and block tags, busy and valid bits and a
// recency rank, and answers one command at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_cmd, in_owner_id, in_block_number, in_slot_in
//   and raise start; the command is taken at a rising edge where start is
//   high and busy is low. busy stays high while the command is worked on.
//   Result channel: out_strobe is high for one cycle with out_slot_out,
//   out_status and out_data_valid; the receiver takes it in that cycle and
//   cannot hold it off. Command code 3 is taken and gives no result.
//   Sequence: a get walks the slot table one slot per cycle through the
//   shared compare unit, then passes a drain and an end state; the strobe
//   rises as the sequencer returns to idle. Mark valid and release read
//   their slot through the same read stage, then a check state strobes
//   the result; a slot index beyond the table is answered in the cycle
//   after the accept. The next command may be taken in the strobe cycle.
//   No new command is taken while a get, mark valid or release is worked
//   on; the tag memory read port and compare unit are used once per slot.
//   Reset: all slots free and empty, slot 0 most recently used, slot
//   SLOT_COUNT-1 least. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit #(
  parameter int SLOT_COUNT = 16,
  parameter int OWNER_BITS = 16,
  parameter int BLOCK_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lbc_pkg::CMD_W-1:0]         in_cmd,
  input  logic [lbc_pkg::OWNER_ID_W-1:0]    in_owner_id,
  input  logic [lbc_pkg::BLOCK_NO_W-1:0]    in_block_number,
  input  logic [lbc_pkg::SLOT_FLD_W-1:0]    in_slot_in,
  output logic                              out_strobe,
  output logic [lbc_pkg::SLOT_FLD_W-1:0]    out_slot_out,
  output logic [lbc_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_data_valid
);
  import lbc_pkg::*;

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int TAG_W = OWNER_BITS + BLOCK_BITS;
  localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

  // Sequencer
  lbc_state_t state_r, state_nxt;

  // Request registers
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic [BLOCK_BITS-1:0] block_r, block_nxt;
  logic [SW-1:0]         cnt_r, cnt_nxt;

  // Slot state
  logic              slot_busy_r  [SLOT_COUNT];
  logic              slot_busy_nxt[SLOT_COUNT];
  logic              slot_valid_r  [SLOT_COUNT];
  logic              slot_valid_nxt[SLOT_COUNT];
  logic [SW-1:0]     rank_r  [SLOT_COUNT];
  logic [SW-1:0]     rank_nxt[SLOT_COUNT];
  logic [TAG_W-1:0]  tag_mem [SLOT_COUNT];

  // Read stage
  logic [TAG_W-1:0] rd_tag_r;
  logic             rd_busy_r;
  logic             rd_valid_r;
  logic [SW-1:0]    rd_rank_r;
  logic [SW-1:0]    rd_idx_r;
  logic             rdv_r;

  // Walk results
  logic          hit_found_r, hit_found_nxt;
  logic [SW-1:0] hit_idx_r, hit_idx_nxt;
  logic [SW-1:0] hit_rank_r, hit_rank_nxt;
  logic          hit_busy_r, hit_busy_nxt;
  logic          hit_valid_r, hit_valid_nxt;
  logic          vic_found_r, vic_found_nxt;
  logic [SW-1:0] vic_idx_r, vic_idx_nxt;
  logic [SW-1:0] vic_rank_r, vic_rank_nxt;

  // Result registers
  logic                  out_strobe_r, out_strobe_nxt;
  logic [SLOT_FLD_W-1:0] out_slot_r, out_slot_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                  out_dv_r, out_dv_nxt;

  // Sequencer controls
  logic accept;
  logic in_range;
  logic walk_step;
  logic get_end;
  logic sel_chk;
  logic tag_we;

  lbc_cmp_t cmp;

  // Shared compare unit
  lbc_slot_cmp #(
    .OWNER_BITS (OWNER_BITS),
    .BLOCK_BITS (BLOCK_BITS),
    .RANK_W     (SW)
  ) u_cmp (
    .key_owner   (owner_r),
    .key_block   (block_r),
    .entry_owner (rd_tag_r[TAG_W-1:BLOCK_BITS]),
    .entry_block (rd_tag_r[BLOCK_BITS-1:0]),
    .entry_busy  (rd_busy_r),
    .entry_valid (rd_valid_r),
    .entry_rank  (rd_rank_r),
    .hit_found   (hit_found_r),
    .hit_rank    (hit_rank_r),
    .vic_found   (vic_found_r),
    .vic_rank    (vic_rank_r),
    .res         (cmp)
  );

  assign in_range = 32'(in_slot_in) < 32'(SLOT_COUNT);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_GET) begin
            state_nxt = ST_WALK;
          end else if ((in_cmd == CMD_MARK || in_cmd == CMD_RELEASE) && in_range) begin
            state_nxt = ST_SEL;
          end
        end
      end
      ST_WALK: begin
        if (cnt_r == LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:   state_nxt = ST_GET_END;
      ST_GET_END: state_nxt = ST_IDLE;
      ST_SEL:     state_nxt = ST_SEL_CHK;
      ST_SEL_CHK: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    accept    = 1'b0;
    walk_step = 1'b0;
    get_end   = 1'b0;
    sel_chk   = 1'b0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_WALK:    walk_step = 1'b1;
      ST_GET_END: get_end   = 1'b1;
      ST_SEL_CHK: sel_chk   = 1'b1;
      default: begin
        walk_step = 1'b0;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    cmd_nxt        = cmd_r;
    owner_nxt      = owner_r;
    block_nxt      = block_r;
    cnt_nxt        = cnt_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rank_nxt   = hit_rank_r;
    hit_busy_nxt   = hit_busy_r;
    hit_valid_nxt  = hit_valid_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_rank_nxt   = vic_rank_r;
    out_strobe_nxt = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_dv_nxt     = out_dv_r;
    tag_we         = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_busy_nxt[i]  = slot_busy_r[i];
      slot_valid_nxt[i] = slot_valid_r[i];
      rank_nxt[i]       = rank_r[i];
    end

    // Take a command
    if (accept) begin
      cmd_nxt       = in_cmd;
      owner_nxt     = OWNER_BITS'(in_owner_id);
      block_nxt     = BLOCK_BITS'(in_block_number);
      hit_found_nxt = 1'b0;
      vic_found_nxt = 1'b0;
      if (in_cmd == CMD_GET) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = SW'(in_slot_in);
      end
      // Reject a slot index beyond the table at once
      if ((in_cmd == CMD_MARK || in_cmd == CMD_RELEASE) && !in_range) begin
        out_strobe_nxt = 1'b1;
        out_slot_nxt   = in_slot_in;
        out_status_nxt = STAT_NOT_HELD;
        out_dv_nxt     = 1'b0;
      end
    end

    // Advance the walk
    if (walk_step) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    // Fold the slot in the read stage into the best hit and victim
    if (rdv_r) begin
      if (cmp.hit_better) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = rd_idx_r;
        hit_rank_nxt  = rd_rank_r;
        hit_busy_nxt  = rd_busy_r;
        hit_valid_nxt = rd_valid_r;
      end
      if (cmp.vic_better) begin
        vic_found_nxt = 1'b1;
        vic_idx_nxt   = rd_idx_r;
        vic_rank_nxt  = rd_rank_r;
      end
    end

    // Finish a get
    if (get_end) begin
      out_strobe_nxt = 1'b1;
      if (hit_found_r) begin
        out_slot_nxt = SLOT_FLD_W'(hit_idx_r);
        if (hit_busy_r) begin
          out_status_nxt = STAT_BUSY;
          out_dv_nxt     = 1'b0;
        end else begin
          slot_busy_nxt[hit_idx_r] = 1'b1;
          out_status_nxt           = STAT_OK;
          out_dv_nxt               = hit_valid_r;
        end
      end else if (vic_found_r) begin
        slot_busy_nxt[vic_idx_r]  = 1'b1;
        slot_valid_nxt[vic_idx_r] = 1'b0;
        tag_we                    = 1'b1;
        out_slot_nxt              = SLOT_FLD_W'(vic_idx_r);
        out_status_nxt            = STAT_OK;
        out_dv_nxt                = 1'b0;
      end else begin
        out_slot_nxt   = '0;
        out_status_nxt = STAT_NONE_FREE;
        out_dv_nxt     = 1'b0;
      end
    end

    // Finish a mark valid or release
    if (sel_chk) begin
      out_strobe_nxt = 1'b1;
      out_slot_nxt   = SLOT_FLD_W'(rd_idx_r);
      if (!rd_busy_r) begin
        out_status_nxt = STAT_NOT_HELD;
        out_dv_nxt     = 1'b0;
      end else if (cmd_r == CMD_MARK) begin
        slot_valid_nxt[rd_idx_r] = 1'b1;
        out_status_nxt           = STAT_OK;
        out_dv_nxt               = 1'b1;
      end else begin
        // Move the slot to the front, pushing the more recent ones back
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (rank_r[i] < rd_rank_r) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        rank_nxt[rd_idx_r]      = '0;
        slot_busy_nxt[rd_idx_r] = 1'b0;
        out_status_nxt          = STAT_OK;
        out_dv_nxt              = rd_valid_r;
      end
    end
  end

  // Control and slot state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rdv_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      hit_found_r  <= 1'b0;
      vic_found_r  <= 1'b0;
      cnt_r        <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_busy_r[i]  <= 1'b0;
        slot_valid_r[i] <= 1'b0;
        rank_r[i]       <= SW'(i);
      end
    end else begin
      state_r      <= state_nxt;
      rdv_r        <= walk_step;
      out_strobe_r <= out_strobe_nxt;
      hit_found_r  <= hit_found_nxt;
      vic_found_r  <= vic_found_nxt;
      cnt_r        <= cnt_nxt;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_busy_r[i]  <= slot_busy_nxt[i];
        slot_valid_r[i] <= slot_valid_nxt[i];
        rank_r[i]       <= rank_nxt[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    owner_r      <= owner_nxt;
    block_r      <= block_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_rank_r   <= hit_rank_nxt;
    hit_busy_r   <= hit_busy_nxt;
    hit_valid_r  <= hit_valid_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_rank_r   <= vic_rank_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_dv_r     <= out_dv_nxt;
  end

  // Read stage: one slot per cycle at the walk counter
  always_ff @(posedge clk) begin
    rd_busy_r  <= slot_busy_r[cnt_r];
    rd_valid_r <= slot_valid_r[cnt_r];
    rd_rank_r  <= rank_r[cnt_r];
    rd_idx_r   <= cnt_r;
  end

  // Tag memory: retag the victim, read at the walk counter
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[vic_idx_r] <= {owner_r, block_r};
    end
    rd_tag_r <= tag_mem[cnt_r];
  end

  assign out_strobe     = out_strobe_r;
  assign out_slot_out   = out_slot_r;
  assign out_status     = out_status_r;
  assign out_data_valid = out_dv_r;

`ifndef SYNTH
  // No result leaves while the table is being walked
  a_no_result_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !out_strobe_r)
    else $error("result strobe during slot walk");

  // A full table answers slot zero with no data
  a_none_free_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r == STAT_NONE_FREE) |-> (out_slot_r == '0 && !out_dv_r))
    else $error("malformed none-free result");

  // A release of a held slot frees it
  a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL_CHK && cmd_r == CMD_RELEASE && rd_busy_r)
      |=> !slot_busy_r[$past(rd_idx_r)])
    else $error("released slot still busy");
`endif

endmodule

// ===== design/lbc_slot_cmp.sv =====
// ----------------------------------------------------------------------------
// lbc_slot_cmp: shared slot compare unit
// Matches one slot's tags against the request key and ranks the slot against
// the best hit and the best victim found so far in the walk.
// ----------------------------------------------------------------------------
module lbc_slot_cmp #(
  parameter int OWNER_BITS = 16,
  parameter int BLOCK_BITS = 32,
  parameter int RANK_W     = 4
) (
  input  logic [OWNER_BITS-1:0] key_owner,
  input  logic [BLOCK_BITS-1:0] key_block,
  input  logic [OWNER_BITS-1:0] entry_owner,
  input  logic [BLOCK_BITS-1:0] entry_block,
  input  logic                  entry_busy,
  input  logic                  entry_valid,
  input  logic [RANK_W-1:0]     entry_rank,
  input  logic                  hit_found,
  input  logic [RANK_W-1:0]     hit_rank,
  input  logic                  vic_found,
  input  logic [RANK_W-1:0]     vic_rank,
  output lbc_pkg::lbc_cmp_t     res
);
  import lbc_pkg::*;

  // Tag match on a held or filled slot
  assign res.match = (entry_busy || entry_valid) &&
                     (entry_owner == key_owner) && (entry_block == key_block);

  // Prefer the most recently used match
  assign res.hit_better = res.match && (!hit_found || (entry_rank < hit_rank));

  // Prefer the least recently used free slot
  assign res.vic_better = !entry_busy && (!vic_found || (entry_rank > vic_rank));

endmodule

// ===== dv/lru_block_buffer_cache_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit_tb: self-checking bench for the LRU slot table
// Drives get, mark-valid and release items through the start/busy handshake,
// predicts every reply with a behavioural copy of the slot table, and checks
// each strobed reply field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit_tb;
  import lbc_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic [SLOT_FLD_W-1:0] slot;
    logic [STATUS_W-1:0]   status;
    logic                  data_valid;
  } cache_reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      in_cmd;
  logic [OWNER_ID_W-1:0] in_owner_id;
  logic [BLOCK_NO_W-1:0] in_block_number;
  logic [SLOT_FLD_W-1:0] in_slot_in;
  logic                  out_strobe;
  logic [SLOT_FLD_W-1:0] out_slot_out;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_data_valid;

  // Shadow slot table
  logic [OWNER_ID_W-1:0] tag_owner [SLOTS];
  logic [BLOCK_NO_W-1:0] tag_block [SLOTS];
  bit                    slot_held [SLOTS];
  bit                    slot_filled [SLOTS];
  int unsigned           slot_rank [SLOTS];

  cache_reply_t expected_replies[$];
  int           fail_count;
  int           idle_pct;

  lru_block_buffer_cache_unit #(
    .SLOT_COUNT(SLOTS),
    .OWNER_BITS(OWNER_ID_W),
    .BLOCK_BITS(BLOCK_NO_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_owner_id(in_owner_id),
    .in_block_number(in_block_number),
    .in_slot_in(in_slot_in),
    .out_strobe(out_strobe),
    .out_slot_out(out_slot_out),
    .out_status(out_status),
    .out_data_valid(out_data_valid)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Update the shadow table for one accepted item and queue its reply
  function automatic void predict_cache_reply(input logic [CMD_W-1:0] cmd,
                                              input logic [OWNER_ID_W-1:0] owner,
                                              input logic [BLOCK_NO_W-1:0] blk,
                                              input logic [SLOT_FLD_W-1:0] sel);
    int           hit;
    int           victim;
    int unsigned  old_rank;
    cache_reply_t r;
    hit    = -1;
    victim = -1;
    r      = '0;
    case (cmd)
      CMD_GET: begin
        // most recently used matching slot wins
        for (int i = 0; i < SLOTS; i++) begin
          if ((slot_held[i] || slot_filled[i]) && tag_owner[i] == owner &&
              tag_block[i] == blk) begin
            if (hit < 0 || slot_rank[i] < slot_rank[hit]) hit = i;
          end
        end
        if (hit >= 0) begin
          r.slot = hit[SLOT_FLD_W-1:0];
          if (slot_held[hit]) begin
            r.status = STAT_BUSY;
          end else begin
            slot_held[hit] = 1'b1;
            r.status       = STAT_OK;
            r.data_valid   = slot_filled[hit];
          end
        end else begin
          // claim the least recently used free slot
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_held[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
              victim = i;
          end
          if (victim < 0) begin
            r.status = STAT_NONE_FREE;
          end else begin
            slot_held[victim]   = 1'b1;
            slot_filled[victim] = 1'b0;
            tag_owner[victim]   = owner;
            tag_block[victim]   = blk;
            r.slot              = victim[SLOT_FLD_W-1:0];
            r.status            = STAT_OK;
          end
        end
      end
      CMD_MARK, CMD_RELEASE: begin
        r.slot = sel;
        if (!slot_held[sel]) begin
          r.status = STAT_NOT_HELD;
        end else if (cmd == CMD_MARK) begin
          slot_filled[sel] = 1'b1;
          r.status         = STAT_OK;
          r.data_valid     = 1'b1;
        end else begin
          // move the slot to the front of the recency order
          old_rank = slot_rank[sel];
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_rank[i] < old_rank) slot_rank[i] = slot_rank[i] + 1;
          end
          slot_rank[sel] = 0;
          slot_held[sel] = 1'b0;
          r.status       = STAT_OK;
          r.data_valid   = slot_filled[sel];
        end
      end
      default: return;
    endcase
    expected_replies.push_back(r);
  endfunction

  // Send one item; start stays high on return so the next item may follow
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic [OWNER_ID_W-1:0] owner,
                           input logic [BLOCK_NO_W-1:0] blk,
                           input logic [SLOT_FLD_W-1:0] sel);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_cmd          <= cmd;
    in_owner_id     <= owner;
    in_block_number <= blk;
    in_slot_in      <= sel;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_cache_reply(cmd, owner, blk, sel);
  endtask

  // Check each strobed reply against the oldest prediction
  always @(posedge clk) begin
    cache_reply_t exp_r;
    if (rst_n && out_strobe) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply: slot %0d status %0d data_valid %0d", $time,
                 out_slot_out, out_status, out_data_valid);
        fail_count++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (out_slot_out !== exp_r.slot) begin
          $display("%0t: slot_out mismatch: expected %0d, actual %0d", $time,
                   exp_r.slot, out_slot_out);
          fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   exp_r.status, out_status);
          fail_count++;
        end
        if (out_data_valid !== exp_r.data_valid) begin
          $display("%0t: data_valid mismatch: expected %0d, actual %0d", $time,
                   exp_r.data_valid, out_data_valid);
          fail_count++;
        end
      end
    end
  end

  // Corner cases: first miss, busy retry, hit on a filled slot, not held,
  // ignored command, table full, and a released empty slot being reclaimed
  task automatic test_directed();
    idle_pct = 0;
    send_item(CMD_GET, '0, '0, '0);
    send_item(CMD_GET, '0, '0, '0);
    send_item(CMD_MARK, '0, '0, 4'd15);
    send_item(CMD_RELEASE, '0, '0, 4'd15);
    send_item(CMD_RELEASE, '1, '1, 4'd15);
    send_item(CMD_GET, '0, '0, '0);
    send_item(CMD_GET, '1, '1, '1);
    send_item(CMD_MARK, '0, '0, 4'd3);
    send_item(CMD_RELEASE, '0, '0, 4'd0);
    send_item(2'd3, '1, '1, '1);
    send_item(CMD_GET, '1, '0, '0);
    send_item(CMD_GET, '0, '1, '0);
    // fill the table, then ask once more
    for (int k = 0; k < 13; k++) begin
      send_item(CMD_GET, OWNER_ID_W'(16'h0100 + k), BLOCK_NO_W'(32'h8000_0000 + k), '0);
    end
    send_item(CMD_RELEASE, '0, '0, 4'd14);
    send_item(CMD_GET, '1, '1, '0);
  endtask

  // Mostly well-formed get/mark/release traffic over a small tag pool,
  // with a drifting target for how many slots are held, plus some noise
  task automatic run_cache_traffic(input int count);
    logic [OWNER_ID_W-1:0] pool_owner [12];
    logic [BLOCK_NO_W-1:0] pool_block [12];
    int                    held_list[$];
    int                    hold_target;
    int                    roll;
    int                    p;
    logic [CMD_W-1:0]      cmd;
    hold_target = 8;
    for (int k = 0; k < 12; k++) begin
      pool_owner[k] = (k < 4) ? OWNER_ID_W'(k) : OWNER_ID_W'($urandom);
      pool_block[k] = (k < 6) ? BLOCK_NO_W'(k % 3) : BLOCK_NO_W'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        hold_target = $urandom_range(1, 17);
        if (idle_pct >= 0) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 20;
            default: idle_pct = 60;
          endcase
        end
      end
      held_list.delete();
      for (int i = 0; i < SLOTS; i++) if (slot_held[i]) held_list.push_back(i);
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_item(CMD_W'($urandom_range(0, 3)), OWNER_ID_W'($urandom),
                  BLOCK_NO_W'($urandom), SLOT_FLD_W'($urandom_range(0, 15)));
      end else if (roll < 12) begin
        cmd = (roll < 9) ? CMD_MARK : CMD_RELEASE;
        send_item(cmd, OWNER_ID_W'($urandom), BLOCK_NO_W'($urandom),
                  SLOT_FLD_W'($urandom_range(0, 15)));
      end else if (held_list.size() == 0 ||
                   (held_list.size() < hold_target && roll < 75)) begin
        p = $urandom_range(0, 11);
        if ($urandom_range(0, 9) == 0) begin
          send_item(CMD_GET, OWNER_ID_W'($urandom), BLOCK_NO_W'($urandom), '0);
        end else begin
          send_item(CMD_GET, pool_owner[p], pool_block[p],
                    SLOT_FLD_W'($urandom_range(0, 15)));
        end
      end else begin
        p   = held_list[$urandom_range(0, held_list.size() - 1)];
        cmd = ($urandom_range(0, 2) == 0) ? CMD_MARK : CMD_RELEASE;
        send_item(cmd, OWNER_ID_W'($urandom), BLOCK_NO_W'($urandom),
                  SLOT_FLD_W'(p));
      end
    end
  endtask

  task automatic test_random_traffic();
    idle_pct = 20;
    run_cache_traffic(1375);
  endtask

  // Final stretch: keep start high, no idling at all
  task automatic test_back_to_back();
    idle_pct = -1;
    run_cache_traffic(150);
  endtask

  initial begin
    fail_count      = 0;
    idle_pct        = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_cmd          <= '0;
    in_owner_id     <= '0;
    in_block_number <= '0;
    in_slot_in      <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      tag_owner[i]   = '0;
      tag_block[i]   = '0;
      slot_held[i]   = 1'b0;
      slot_filled[i] = 1'b0;
      slot_rank[i]   = i;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_back_to_back();

    // drain outstanding replies, then allow for an ignored command in flight
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    if (fail_count == 0) begin
      $display("lru_block_buffer_cache_unit regression: pass");
    end else begin
      $display("lru_block_buffer_cache_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12000000;
    $display("lru_block_buffer_cache_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lbc_pkg.sv
design/lbc_slot_cmp.sv
design/lru_block_buffer_cache_unit.sv
dv/lru_block_buffer_cache_unit_tb.sv
